@@ rtl/fss_pkg.sv @@
// Shared types, constants and the microcode program of the smooth size search.
package fss_pkg;

   localparam int SIZE_WIDTH = 32;
   localparam int RES_WIDTH  = SIZE_WIDTH + 1;
   localparam int XW         = SIZE_WIDTH + 5;
   localparam int PC_WIDTH   = 5;
   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 64;

   localparam logic [RES_WIDTH-1:0] MAX_SIZE_RESET = RES_WIDTH'(2147483647);

   localparam logic [1:0] FACTOR_5   = 2'd0;
   localparam logic [1:0] FACTOR_7   = 2'd1;
   localparam logic [1:0] FACTOR_11  = 2'd2;
   localparam logic [1:0] FACTOR_BAD = 2'd3;

   localparam logic REG_MAX_SIZE = 1'b0;

   localparam logic [PC_WIDTH-1:0] STEP_U0       = 5'd0;
   localparam logic [PC_WIDTH-1:0] STEP_U1       = 5'd1;
   localparam logic [PC_WIDTH-1:0] STEP_U2       = 5'd2;
   localparam logic [PC_WIDTH-1:0] STEP_U3       = 5'd3;
   localparam logic [PC_WIDTH-1:0] STEP_U4       = 5'd4;
   localparam logic [PC_WIDTH-1:0] STEP_U5       = 5'd5;
   localparam logic [PC_WIDTH-1:0] STEP_U6       = 5'd6;
   localparam logic [PC_WIDTH-1:0] STEP_U7       = 5'd7;
   localparam logic [PC_WIDTH-1:0] STEP_D0       = 5'd8;
   localparam logic [PC_WIDTH-1:0] STEP_D1       = 5'd9;
   localparam logic [PC_WIDTH-1:0] STEP_D2       = 5'd10;
   localparam logic [PC_WIDTH-1:0] STEP_D3       = 5'd11;
   localparam logic [PC_WIDTH-1:0] STEP_D4       = 5'd12;
   localparam logic [PC_WIDTH-1:0] STEP_D5       = 5'd13;
   localparam logic [PC_WIDTH-1:0] STEP_D6       = 5'd14;
   localparam logic [PC_WIDTH-1:0] STEP_D7       = 5'd15;
   localparam logic [PC_WIDTH-1:0] STEP_OUT_N    = 5'd16;
   localparam logic [PC_WIDTH-1:0] STEP_OUT_BEST = 5'd17;
   localparam logic [PC_WIDTH-1:0] STEP_OUT_BAD  = 5'd18;

   typedef struct packed {
      logic                  cmd;
      logic [SIZE_WIDTH-1:0] size;
      logic [1:0]            max_factor;
   } req_type;

   typedef struct packed {
      logic [RES_WIDTH-1:0] result_size;
      logic                 bad_factor;
   } rsp_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_SMALL,
      COND_A_UP,
      COND_B_UP,
      COND_C_UP,
      COND_X_LT_N,
      COND_X_EQ_N,
      COND_X_ODD,
      COND_A_DN,
      COND_B_DN,
      COND_C_DN,
      COND_X2_LE_N,
      COND_X3_LE_N
   } cond_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT_UP,
      OP_INIT_DN,
      OP_B_A,
      OP_C_B,
      OP_X_C,
      OP_A_MUL11,
      OP_B_MUL7,
      OP_C_MUL5,
      OP_X_MUL2,
      OP_X_MUL3,
      OP_X_HALF,
      OP_BEST_MIN,
      OP_BEST_MAX,
      OP_OUT_N,
      OP_OUT_BEST,
      OP_OUT_BAD
   } op_type;

   typedef struct packed {
      cond_type              cond;
      op_type                op_t;
      op_type                op_f;
      logic [PC_WIDTH-1:0]   jump_t;
      logic [PC_WIDTH-1:0]   jump_f;
   } uword_type;

   typedef struct packed {
      logic load;
      op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic is_small;
      logic a_up;
      logic b_up;
      logic c_up;
      logic x_lt_n;
      logic x_eq_n;
      logic x_odd;
      logic a_dn;
      logic b_dn;
      logic c_dn;
      logic x2_le_n;
      logic x3_le_n;
   } cond_flags_type;

   function automatic uword_type ucode_rom(input logic [PC_WIDTH-1:0] step);
      uword_type w;
      case (step)
         STEP_U0: w = '{COND_SMALL, OP_NONE, OP_INIT_UP, STEP_OUT_N, STEP_U1};
         STEP_U1: w = '{COND_A_UP, OP_B_A, OP_NONE, STEP_U2, STEP_OUT_BEST};
         STEP_U2: w = '{COND_B_UP, OP_C_B, OP_A_MUL11, STEP_U3, STEP_U1};
         STEP_U3: w = '{COND_C_UP, OP_X_C, OP_B_MUL7, STEP_U4, STEP_U2};
         STEP_U4: w = '{COND_X_LT_N, OP_X_MUL2, OP_NONE, STEP_U4, STEP_U5};
         STEP_U5: w = '{COND_X_EQ_N, OP_NONE, OP_NONE, STEP_OUT_N, STEP_U6};
         STEP_U6: w = '{COND_X_LT_N, OP_X_MUL3, OP_BEST_MIN, STEP_U5, STEP_U7};
         STEP_U7: w = '{COND_X_ODD, OP_C_MUL5, OP_X_HALF, STEP_U3, STEP_U5};
         STEP_D0: w = '{COND_SMALL, OP_NONE, OP_INIT_DN, STEP_OUT_N, STEP_D1};
         STEP_D1: w = '{COND_A_DN, OP_B_A, OP_NONE, STEP_D2, STEP_OUT_BEST};
         STEP_D2: w = '{COND_B_DN, OP_C_B, OP_A_MUL11, STEP_D3, STEP_D1};
         STEP_D3: w = '{COND_C_DN, OP_X_C, OP_B_MUL7, STEP_D4, STEP_D2};
         STEP_D4: w = '{COND_X2_LE_N, OP_X_MUL2, OP_BEST_MAX, STEP_D4, STEP_D5};
         STEP_D5: w = '{COND_X3_LE_N, OP_X_MUL3, OP_NONE, STEP_D6, STEP_D7};
         STEP_D6: w = '{COND_ALWAYS, OP_BEST_MAX, OP_NONE, STEP_D5, STEP_D5};
         STEP_D7: w = '{COND_X_ODD, OP_C_MUL5, OP_X_HALF, STEP_D3, STEP_D6};
         STEP_OUT_N: w = '{COND_ALWAYS, OP_OUT_N, OP_NONE, STEP_U0, STEP_U0};
         STEP_OUT_BEST: w = '{COND_ALWAYS, OP_OUT_BEST, OP_NONE, STEP_U0, STEP_U0};
         STEP_OUT_BAD: w = '{COND_ALWAYS, OP_OUT_BAD, OP_NONE, STEP_U0, STEP_U0};
         default: w = '{COND_ALWAYS, OP_OUT_BAD, OP_NONE, STEP_U0, STEP_U0};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/fss_seq.sv @@
// Microcode sequencer: step counter, program table and conditional branching.
module fss_seq import fss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  req_type        req_data,
   input  cond_flags_type flags,
   output logic           busy,
   output dp_ctrl_type    ctrl
);

   logic                busy_ff, busy_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   uword_type           uw;
   logic                taken;
   op_type              op;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= STEP_U0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   always_comb begin
      uw = ucode_rom(pc_ff);
      case (uw.cond)
         COND_ALWAYS:  taken = 1'b1;
         COND_SMALL:   taken = flags.is_small;
         COND_A_UP:    taken = flags.a_up;
         COND_B_UP:    taken = flags.b_up;
         COND_C_UP:    taken = flags.c_up;
         COND_X_LT_N:  taken = flags.x_lt_n;
         COND_X_EQ_N:  taken = flags.x_eq_n;
         COND_X_ODD:   taken = flags.x_odd;
         COND_A_DN:    taken = flags.a_dn;
         COND_B_DN:    taken = flags.b_dn;
         COND_C_DN:    taken = flags.c_dn;
         COND_X2_LE_N: taken = flags.x2_le_n;
         COND_X3_LE_N: taken = flags.x3_le_n;
         default:      taken = 1'b1;
      endcase
      op = taken ? uw.op_t : uw.op_f;

      busy_in   = busy_ff;
      pc_in     = pc_ff;
      ctrl.load = 1'b0;
      ctrl.op   = OP_NONE;
      if (busy_ff) begin
         ctrl.op = op;
         pc_in   = taken ? uw.jump_t : uw.jump_f;
         if (op == OP_OUT_N || op == OP_OUT_BEST || op == OP_OUT_BAD) begin
            busy_in = 1'b0;
         end
      end else if (start) begin
         ctrl.load = 1'b1;
         busy_in   = 1'b1;
         if (req_data.max_factor == FACTOR_BAD) begin
            pc_in = STEP_OUT_BAD;
         end else if (req_data.cmd) begin
            pc_in = STEP_U0;
         end else begin
            pc_in = STEP_D0;
         end
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/fss_dp.sv @@
// Search datapath: working registers, constant-factor scaling and branch conditions.
module fss_dp import fss_pkg::*; (
   input  logic                  clock,
   input  req_type               req_data,
   input  dp_ctrl_type           ctrl,
   output cond_flags_type        flags,
   output logic [SIZE_WIDTH-1:0] n_value,
   output logic [XW-1:0]         best_value
);

   logic [SIZE_WIDTH-1:0] n_ff, n_in;
   logic [1:0]            fac_ff, fac_in;
   logic [XW-1:0]         a_ff, a_in;
   logic [XW-1:0]         b_ff, b_in;
   logic [XW-1:0]         c_ff, c_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [XW-1:0]         best_ff, best_in;
   logic [XW-1:0]         n_ext;
   logic [XW-1:0]         lim_p1;
   logic [XW+1:0]         x3;
   logic [XW+1:0]         n_wide;
   logic                  lim11, lim7;

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      fac_ff  <= fac_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      x_ff    <= x_in;
      best_ff <= best_in;
   end

   always_comb begin
      n_ext  = XW'(n_ff);
      n_wide = (XW + 2)'(n_ff);
      x3     = {2'b00, x_ff} + {1'b0, x_ff, 1'b0};
      lim11  = (fac_ff == FACTOR_11);
      lim7   = (fac_ff == FACTOR_7) || (fac_ff == FACTOR_11);
      case (fac_ff)
         FACTOR_5: lim_p1 = XW'(6);
         FACTOR_7: lim_p1 = XW'(8);
         default:  lim_p1 = XW'(12);
      endcase

      flags.is_small = (n_ext <= lim_p1);
      flags.a_up    = lim11 ? (a_ff < best_ff) : (a_ff < XW'(2));
      flags.b_up    = lim7 ? (b_ff < best_ff) : (b_ff < XW'(2));
      flags.c_up    = (c_ff < best_ff);
      flags.x_lt_n  = (x_ff < n_ext);
      flags.x_eq_n  = (x_ff == n_ext);
      flags.x_odd   = x_ff[0];
      flags.a_dn    = lim11 ? (a_ff <= n_ext) : (a_ff <= XW'(1));
      flags.b_dn    = lim7 ? (b_ff <= n_ext) : (b_ff <= XW'(1));
      flags.c_dn    = (c_ff <= n_ext);
      flags.x2_le_n = ({1'b0, x_ff, 1'b0} <= n_wide);
      flags.x3_le_n = (x3 <= n_wide);
   end

   always_comb begin
      n_in    = n_ff;
      fac_in  = fac_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      x_in    = x_ff;
      best_in = best_ff;
      if (ctrl.load) begin
         n_in   = req_data.size;
         fac_in = req_data.max_factor;
      end
      case (ctrl.op)
         OP_INIT_UP: begin
            best_in = XW'({n_ff, 1'b0});
            a_in    = XW'(1);
         end
         OP_INIT_DN: begin
            best_in = XW'(1);
            a_in    = XW'(1);
         end
         OP_B_A:      b_in = a_ff;
         OP_C_B:      c_in = b_ff;
         OP_X_C:      x_in = c_ff;
         OP_A_MUL11:  a_in = (a_ff << 3) + (a_ff << 1) + a_ff;
         OP_B_MUL7:   b_in = (b_ff << 3) - b_ff;
         OP_C_MUL5:   c_in = (c_ff << 2) + c_ff;
         OP_X_MUL2:   x_in = x_ff << 1;
         OP_X_MUL3:   x_in = x3[XW-1:0];
         OP_X_HALF:   x_in = x_ff >> 1;
         OP_BEST_MIN: best_in = (x_ff < best_ff) ? x_ff : best_ff;
         OP_BEST_MAX: best_in = (x_ff > best_ff) ? x_ff : best_ff;
         default: begin
         end
      endcase
   end

   assign n_value    = n_ff;
   assign best_value = best_ff;

endmodule

@@ rtl/fft_smooth_size_search.sv @@
// Top level of the smooth transform size search with its register port.
// The result is registered. A bad factor code goes straight to the STEP_OUT_BAD step;
// small sizes pass the first search step and then STEP_OUT_N. Searches advance one
// step a cycle through the program table until one of the output steps ends them.
// One request at a time, busy meanwhile; the receiver cannot stall the result.
// Synchronous reset idles the sequencer and sets max_size to 2147483647.
module fft_smooth_size_search import fss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   logic [RES_WIDTH-1:0] max_size_ff, max_size_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;
   dp_ctrl_type          ctrl;
   cond_flags_type       flags;
   logic [SIZE_WIDTH-1:0] n_value;
   logic [XW-1:0]        best_value;
   logic [RES_WIDTH-1:0] cand;

   fss_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .flags    (flags),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   fss_dp u_dp (
      .clock      (clock),
      .req_data   (req_data),
      .ctrl       (ctrl),
      .flags      (flags),
      .n_value    (n_value),
      .best_value (best_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff   <= MAX_SIZE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         max_size_ff   <= max_size_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      max_size_in = max_size_ff;
      if (psel && penable && pwrite && paddr[3] == REG_MAX_SIZE) begin
         max_size_in = pwdata[RES_WIDTH-1:0];
      end
   end

   always_comb begin
      cand          = (ctrl.op == OP_OUT_N) ? RES_WIDTH'(n_value) : best_value[RES_WIDTH-1:0];
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (ctrl.op)
         OP_OUT_N, OP_OUT_BEST: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.bad_factor  = 1'b0;
            rsp_in.result_size = (cand > max_size_ff) ? '0 : cand;
         end
         OP_OUT_BAD: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.bad_factor  = 1'b1;
            rsp_in.result_size = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[3] == REG_MAX_SIZE) ? DATA_WIDTH'(max_size_ff) : '0;

endmodule
